FILE: rtl/ida_pkg.sv
package ida_pkg;

  localparam int DIGITS_MAX = 10;
  localparam int DIGIT_W    = 4;
  localparam int BUF_W      = DIGITS_MAX * DIGIT_W;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // One converted number: digits packed most significant at the top nibble
  typedef struct packed {
    logic               neg;
    logic [3:0]         nd;
    logic [BUF_W-1:0]   digits;
  } num_rec_t;

  typedef struct packed {
    logic     push;
    num_rec_t rec;
  } wr_if_t;

  typedef struct packed {
    logic     avail;
    num_rec_t rec;
  } rd_if_t;

endpackage

FILE: rtl/ida_front.sv
module ida_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         value,
  input  logic                is_signed,
  output logic                busy,
  input  logic                q_full,
  output ida_pkg::wr_if_t     wr
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state, state_next;
  logic [31:0]  cur;
  logic [3:0]   nd;
  logic         neg;
  logic [ida_pkg::BUF_W-1:0] digs;

  logic [63:0]  prod;
  logic [28:0]  q;
  logic [3:0]   ten_q_lo;
  logic [3:0]   digit;
  logic         neg_in;

  assign neg_in   = is_signed & value[31];
  assign prod     = {32'd0, cur} * {32'd0, ida_pkg::RECIP_TEN};
  assign q        = prod[63:ida_pkg::RECIP_SHIFT];
  // only the low nibble of q*10 matters since the remainder is below ten
  assign ten_q_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign digit    = cur[3:0] - ten_q_lo;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (start) state_next = F_CONV;
      F_CONV: if (q == 29'd0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (start) begin
          neg <= neg_in;
          cur <= neg_in ? (32'd0 - value) : value;
          nd  <= 4'd0;
        end
      end
      F_CONV: begin
        // shift each new digit in from the top; the last one ends up highest
        digs <= {digit, digs[ida_pkg::BUF_W-1:ida_pkg::DIGIT_W]};
        nd   <= nd + 4'd1;
        cur  <= {3'b000, q};
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != F_IDLE);
  assign wr   = '{push: (state == F_PUSH) && !q_full,
                  rec:  '{neg: neg, nd: nd, digits: digs}};

  property p_conv_nd_bound;
    @(posedge clk) disable iff (rst)
      (state == F_CONV) |-> (nd < 4'(ida_pkg::DIGITS_MAX));
  endproperty
  a_conv_nd_bound: assert property (p_conv_nd_bound)
    else $error("front: digit count overflow");

  property p_push_nonempty;
    @(posedge clk) disable iff (rst)
      wr.push |-> (nd != 4'd0);
  endproperty
  a_push_nonempty: assert property (p_push_nonempty)
    else $error("front: pushed a number with no digits");

endmodule

FILE: rtl/ida_queue.sv
module ida_queue (
  input  logic            clk,
  input  logic            rst,
  input  ida_pkg::wr_if_t wr,
  output logic            full,
  input  logic            pop,
  output ida_pkg::rd_if_t rd
);

  ida_pkg::num_rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign do_push = wr.push && !full;
  assign do_pop  = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr.rec;
  end

  assign rd.avail = (count != 2'd0);
  assign rd.rec   = entries[rd_ptr];

  property p_no_push_when_full;
    @(posedge clk) disable iff (rst)
      full |-> !wr.push;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("queue: push while full");

endmodule

FILE: rtl/ida_back.sv
module ida_back (
  input  logic            clk,
  input  logic            rst,
  input  ida_pkg::rd_if_t rd,
  output logic            pop,
  output logic            char_strobe,
  output logic [7:0]      ascii_char,
  output logic            last,
  output logic [3:0]      char_count
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_MINUS = 3'b010,
    B_DIGIT = 3'b100
  } back_state_t;

  back_state_t state, state_next;
  logic [ida_pkg::BUF_W-1:0] buf_digits;
  logic [3:0] remaining;
  logic [3:0] total;
  logic       fin;

  assign pop = (state == B_IDLE) && rd.avail;
  assign fin = (state == B_DIGIT) && (remaining == 4'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (rd.avail) state_next = rd.rec.neg ? B_MINUS : B_DIGIT;
      B_MINUS: state_next = B_DIGIT;
      B_DIGIT: if (remaining == 4'd1) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      char_strobe <= 1'b0;
      last        <= 1'b0;
      char_count  <= 4'd0;
    end else begin
      state       <= state_next;
      char_strobe <= (state == B_MINUS) || (state == B_DIGIT);
      last        <= fin;
      char_count  <= fin ? total : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (rd.avail) begin
          buf_digits <= rd.rec.digits;
          remaining  <= rd.rec.nd;
          total      <= rd.rec.nd + {3'b000, rd.rec.neg};
        end
      end
      B_MINUS: begin
        ascii_char <= ida_pkg::CHAR_MINUS;
      end
      B_DIGIT: begin
        ascii_char <= ida_pkg::CHAR_ZERO
                    + {4'd0, buf_digits[ida_pkg::BUF_W-1 -: ida_pkg::DIGIT_W]};
        buf_digits <= {buf_digits[ida_pkg::BUF_W-ida_pkg::DIGIT_W-1:0],
                       {ida_pkg::DIGIT_W{1'b0}}};
        remaining  <= remaining - 4'd1;
      end
      default: begin
      end
    endcase
  end

  property p_last_has_count;
    @(posedge clk) disable iff (rst)
      last |-> (char_strobe && char_count != 4'd0 && char_count <= 4'd11);
  endproperty
  a_last_has_count: assert property (p_last_has_count)
    else $error("back: last without valid count");

  property p_count_only_on_last;
    @(posedge clk) disable iff (rst)
      (char_count != 4'd0) |-> last;
  endproperty
  a_count_only_on_last: assert property (p_count_only_on_last)
    else $error("back: count shown on a non-final character");

  property p_minus_then_digit;
    @(posedge clk) disable iff (rst)
      (state == B_MINUS) |=> (state == B_DIGIT);
  endproperty
  a_minus_then_digit: assert property (p_minus_then_digit)
    else $error("back: sign not followed by a digit");

endmodule

FILE: rtl/int_to_decimal_ascii.sv
// Formats a 32-bit word as decimal ASCII, most significant character first,
// '-' leading for a negative signed value, no leading zeros. Raise start with
// value and is_signed; the item is taken when busy is low. The front end
// takes the item in its idle state, then computes one decimal digit per step
// (a multiply-by-reciprocal divide by ten), then hands the number to a
// two-deep queue, waiting while the queue is full; it can take the next item
// while the back end is still emitting. The back end loads a number in its
// idle state and then emits one character per cycle. Each character appears
// for exactly one cycle with char_strobe high and cannot be held off; last
// marks the final character, which carries the character count (1 to 11).
module int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  input  logic        is_signed,
  output logic        char_strobe,
  output logic [7:0]  ascii_char,
  output logic        last,
  output logic [3:0]  char_count
);

  ida_pkg::wr_if_t wr;
  ida_pkg::rd_if_t rd;
  logic            q_full;
  logic            pop;

  ida_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .is_signed (is_signed),
    .busy      (busy),
    .q_full    (q_full),
    .wr        (wr)
  );

  ida_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (q_full),
    .pop  (pop),
    .rd   (rd)
  );

  ida_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd          (rd),
    .pop         (pop),
    .char_strobe (char_strobe),
    .ascii_char  (ascii_char),
    .last        (last),
    .char_count  (char_count)
  );

endmodule
